### design/arbt_pkg.sv
// Shared types and constants for the address range breakpoint table.
// Used by the interfaces, the controller, the datapath and the top level.
package arbt_pkg;

  // Operation codes carried in the func field
  localparam logic [1:0] FUNC_QUERY = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam int FUNC_W = 2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // latch the accepted item
    logic compare;  // register per-entry compare flags
    logic commit;   // update table and load the result register
  } cmd_t;

endpackage

### design/arbt_if.sv
// Valid/ready channel interfaces for the breakpoint table request and result.
// Depends on arbt_pkg for the func field width.
interface arbt_req_if #(
  parameter int ADDR_W = 24
);
  logic                      valid;
  logic                      ready;
  logic [arbt_pkg::FUNC_W-1:0] func;
  logic [ADDR_W-1:0]         addr_low;
  logic [ADDR_W-1:0]         addr_high;

  modport source (output valid, func, addr_low, addr_high, input ready);
  modport sink   (input valid, func, addr_low, addr_high, output ready);
endinterface

interface arbt_rsp_if #(
  parameter int CNT_W = 5
);
  logic             valid;
  logic             ready;
  logic             hit;
  logic             status;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, hit, status, entry_count, input ready);
  modport sink   (input valid, hit, status, entry_count, output ready);
endinterface

### design/arbt_ctrl.sv
// Controller for the breakpoint table: sequences load, compare and commit.
// Depends on arbt_pkg for the command struct.
module arbt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output arbt_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_COMMIT
  } state_t;

  state_t state;
  logic   out_free;

  // Result register may be refilled when empty or being drained
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // Command decode
  always_comb begin
    cmd.load    = (state == S_IDLE) && req_valid;
    cmd.compare = (state == S_CMP);
    cmd.commit  = (state == S_COMMIT) && out_free;
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) state <= S_CMP;
        end
        S_CMP: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // Set by a commit, cleared by a result transfer
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Commit never overwrites a result that is still waiting
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || rsp_ready))
    else $error("commit while result pending");

  // A loaded item is always compared in the next cycle
  a_load_cmp: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.compare)
    else $error("load not followed by compare");

  // No new item is taken while one is between compare and commit
  a_cmp_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.compare |=> !req_ready)
    else $error("accepting during compare");

  // Every commit presents a result
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("commit without result");

endmodule

### design/arbt_dpath.sv
// Datapath for the breakpoint table: sorted range cells, compare flags,
// entry count and the result register. Depends on arbt_pkg.
module arbt_dpath #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 24,
  parameter int CNT_W  = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  arbt_pkg::cmd_t              cmd,
  input  logic [arbt_pkg::FUNC_W-1:0] func,
  input  logic [ADDR_W-1:0]           addr_low,
  input  logic [ADDR_W-1:0]           addr_high,
  output logic                        hit,
  output logic                        status,
  output logic [CNT_W-1:0]            entry_count
);

  // Latched item
  logic [arbt_pkg::FUNC_W-1:0] op_func;
  logic [ADDR_W-1:0]           op_low;
  logic [ADDR_W-1:0]           op_high;

  // Table cells and per-cell flags
  logic [ADDR_W-1:0] lo_q [DEPTH];
  logic [ADDR_W-1:0] hi_q [DEPTH];
  logic [DEPTH-1:0]  ins_q;   // cell takes new or shifted entry on add
  logic [DEPTH-1:0]  inr_q;   // cell holds a range covering the address
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              full;
  logic              do_shift;

  assign full     = (count == CNT_W'(DEPTH));
  assign do_shift = cmd.commit && (op_func == arbt_pkg::FUNC_ADD) && !full;

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= func;
      op_low  <= addr_low;
      op_high <= addr_high;
    end
  end

  // Per-cell compare and insert/shift
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic valid_k;
    assign valid_k = CNT_W'(k) < count;

    always_ff @(posedge clk) begin
      if (cmd.compare) begin
        ins_q[k] <= valid_k ? (lo_q[k] > op_low) : (CNT_W'(k) == count);
        inr_q[k] <= valid_k && (lo_q[k] <= op_low) && (hi_q[k] >= op_low);
      end
    end

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (do_shift && ins_q[k]) begin
          lo_q[k] <= op_low;
          hi_q[k] <= op_high;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (do_shift && ins_q[k]) begin
          lo_q[k] <= ins_q[k-1] ? lo_q[k-1] : op_low;
          hi_q[k] <= ins_q[k-1] ? hi_q[k-1] : op_high;
        end
      end
    end
  end

  // Count after the operation
  always_comb begin
    count_next = count;
    unique case (op_func)
      arbt_pkg::FUNC_ADD:   if (!full) count_next = count + CNT_W'(1);
      arbt_pkg::FUNC_CLEAR: count_next = '0;
      default:              count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit         <= (op_func == arbt_pkg::FUNC_QUERY) && (|inr_q);
      status      <= (op_func == arbt_pkg::FUNC_ADD) && full;
      entry_count <= count_next;
    end
  end

endmodule

### design/address_range_breakpoint_table.sv
// Address range breakpoint table: holds up to TABLE_DEPTH inclusive address
// ranges sorted by low bound and answers query, add and clear operations
// with one result each (hit, full status, entry count). One item is handled
// at a time: the transfer cycle latches the item, a compare cycle checks
// every table entry in parallel against the latched address into registered
// flags, and a commit cycle shifts the table for an add, updates the count
// and loads the result register. The commit waits while the previous result
// has not been taken, but the next item is accepted as soon as the commit is
// done. Entries have no reset; only the count is cleared.
module address_range_breakpoint_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 24
) (
  input logic clk,
  input logic rst,
  arbt_req_if.sink   req,
  arbt_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  arbt_pkg::cmd_t cmd;

  // Sequencing
  arbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Table and result
  arbt_dpath #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_BITS),
    .CNT_W  (CNT_W)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (req.func),
    .addr_low    (req.addr_low),
    .addr_high   (req.addr_high),
    .hit         (rsp.hit),
    .status      (rsp.status),
    .entry_count (rsp.entry_count)
  );

endmodule

### test/testbench.sv
// Self-checking bench for address_range_breakpoint_table: directed rows, then random
// query/add/clear traffic under several idle/stall mixes, checked against a predictor.
// Depends on arbt_pkg, the arbt_req_if/arbt_rsp_if interfaces and the table RTL.
module testbench;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_BITS = 24;
  localparam int CNT_BITS = 5;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 150;  // per idling phase
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    logic                hit;
    logic                status;
    logic [CNT_BITS-1:0] entry_count;
  } bp_result_t;

  // One directed row; reps > 1 steps both bounds by step on each repeat
  typedef struct {
    logic [1:0] func;
    addr_t      lo;
    addr_t      hi;
    int         reps;
    addr_t      step;
    bit         typed;
    bp_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  arbt_req_if #(.ADDR_W(ADDR_BITS)) req_ch ();
  arbt_rsp_if #(.CNT_W(CNT_BITS)) rsp_ch ();

  address_range_breakpoint_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ADDR_BITS  (ADDR_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the range table
  addr_t         bp_low_bounds [TABLE_DEPTH];
  addr_t         bp_high_bounds[TABLE_DEPTH];
  int            bp_count = 0;

  bp_result_t    pending_results[$];
  int            errors = 0;
  int            cycle_count = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;
  int            hold_left = 0;
  bit            hold_req = 1'b0;   // toggled by the sequence to start a hold-off
  bit            hold_seen = 1'b0;  // last toggle taken by the result side

  // Side-band that travels with the offered item: a hand-typed expectation
  bit            side_typed = 1'b0;
  bp_result_t    side_res = '0;

  // Apply one operation to the shadow table and return its result
  function automatic bp_result_t apply_breakpoint_op(logic [1:0] f, addr_t lo, addr_t hi);
    bp_result_t r;
    int pos;
    r = '0;
    case (f)
      arbt_pkg::FUNC_QUERY: begin
        for (int k = 0; k < bp_count; k++) begin
          if (bp_low_bounds[k] > lo) break;
          if (bp_high_bounds[k] >= lo) begin
            r.hit = 1'b1;
            break;
          end
        end
      end
      arbt_pkg::FUNC_ADD: begin
        if (bp_count >= TABLE_DEPTH) begin
          r.status = 1'b1;
        end else begin
          pos = bp_count;
          for (int k = 0; k < bp_count; k++) begin
            if (bp_low_bounds[k] > lo) begin
              pos = k;
              break;
            end
          end
          for (int k = bp_count; k > pos; k--) begin
            bp_low_bounds[k] = bp_low_bounds[k-1];
            bp_high_bounds[k] = bp_high_bounds[k-1];
          end
          bp_low_bounds[pos] = lo;
          bp_high_bounds[pos] = hi;
          bp_count++;
        end
      end
      arbt_pkg::FUNC_CLEAR: bp_count = 0;
      default: ;
    endcase
    r.entry_count = CNT_BITS'(bp_count);
    return r;
  endfunction

  // Transfer monitor: check results first, then record the expectation of a new item
  always @(posedge clk) begin
    bp_result_t got, want, pred;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.hit, rsp_ch.status, rsp_ch.entry_count};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result hit=%0b status=%0b count=%0d", $time,
                   got.hit, got.status, got.entry_count);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0b, got %0b", $time, want.hit, got.hit);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0b, got %0b", $time, want.status, got.status);
            errors++;
          end
          if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d, got %0d", $time, want.entry_count,
                     got.entry_count);
            errors++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pred = apply_breakpoint_op(req_ch.func, req_ch.addr_low, req_ch.addr_high);
        pending_results.push_back(side_typed ? side_res : pred);
      end
    end
  end

  // Result side: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one item and return at the edge of its transfer
  task automatic offer_item(input logic [1:0] f, input addr_t lo, input addr_t hi,
                            input bit typed, input bp_result_t res);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= f;
    req_ch.addr_low <= lo;
    req_ch.addr_high <= hi;
    side_typed <= typed;
    side_res <= res;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Address biased toward stored bounds and the ends of the space
  function automatic addr_t pick_addr();
    addr_t base;
    int k;
    case ($urandom_range(3))
      0: return addr_t'($urandom);
      1: return addr_t'($urandom_range(255));
      2: return addr_t'(24'hffffff - $urandom_range(255));
      default: begin
        if (bp_count == 0) return addr_t'($urandom);
        k = $urandom_range(bp_count - 1);
        base = $urandom_range(1) ? bp_low_bounds[k] : bp_high_bounds[k];
        return base + addr_t'($urandom_range(2)) - addr_t'(1);
      end
    endcase
  endfunction

  // Random well-formed item: mostly queries and adds, occasional clear or unused code
  task automatic offer_random_item(output bit counted);
    logic [1:0] f;
    addr_t lo, hi;
    int r;
    r = $urandom_range(99);
    if (r < 48) f = arbt_pkg::FUNC_QUERY;
    else if (r < 88) f = arbt_pkg::FUNC_ADD;
    else if (r < 91) f = arbt_pkg::FUNC_CLEAR;
    else if (r < 95) f = FUNC_UNUSED;
    else f = 2'($urandom_range(3));
    lo = pick_addr();
    case ($urandom_range(3))
      0: hi = lo;
      1: hi = lo + addr_t'($urandom_range(255));
      2: hi = lo + addr_t'($urandom_range(16'hffff));
      default: hi = addr_t'($urandom);
    endcase
    offer_item(f, lo, hi, 1'b0, '0);
    counted = (f != FUNC_UNUSED);
  endtask

  initial begin
    stim_row_t dir_rows[$];
    stim_row_t row;
    int idle_set[4];
    int stall_set[4];
    int n;
    bit counted;

    req_ch.valid = 1'b0;
    req_ch.func = arbt_pkg::FUNC_QUERY;
    req_ch.addr_low = '0;
    req_ch.addr_high = '0;
    idle_set = '{0, 52, 0, 29};
    stall_set = '{0, 0, 52, 29};

    // Empty table, unused code, clear on empty
    dir_rows.push_back('{arbt_pkg::FUNC_QUERY, 24'h000000, 24'h000000, 1, 0, 1, '{0, 0, 0}});
    dir_rows.push_back('{arbt_pkg::FUNC_QUERY, 24'hffffff, 24'hffffff, 1, 0, 1, '{0, 0, 0}});
    dir_rows.push_back('{FUNC_UNUSED, 24'hffffff, 24'hffffff, 1, 0, 1, '{0, 0, 0}});
    dir_rows.push_back('{arbt_pkg::FUNC_CLEAR, 24'hffffff, 24'h000000, 1, 0, 1, '{0, 0, 0}});
    // Single addresses at both ends of the space
    dir_rows.push_back('{arbt_pkg::FUNC_ADD, 24'h000000, 24'h000000, 1, 0, 1, '{0, 0, 1}});
    dir_rows.push_back('{arbt_pkg::FUNC_ADD, 24'hffffff, 24'hffffff, 1, 0, 1, '{0, 0, 2}});
    dir_rows.push_back('{arbt_pkg::FUNC_QUERY, 24'h000000, 24'h000000, 1, 0, 1, '{1, 0, 2}});
    dir_rows.push_back('{arbt_pkg::FUNC_QUERY, 24'hffffff, 24'h000000, 1, 0, 1, '{1, 0, 2}});
    dir_rows.push_back('{arbt_pkg::FUNC_QUERY, 24'h000001, 24'hffffff, 1, 0, 1, '{0, 0, 2}});
    // Inverted range never hits
    dir_rows.push_back('{arbt_pkg::FUNC_ADD, 24'h800000, 24'h7fffff, 1, 0, 0, '0});
    dir_rows.push_back('{arbt_pkg::FUNC_QUERY, 24'h800000, 24'h000000, 1, 0, 0, '0});
    // Equal low bounds go after the existing entry
    dir_rows.push_back('{arbt_pkg::FUNC_ADD, 24'h000100, 24'h000200, 1, 0, 0, '0});
    dir_rows.push_back('{arbt_pkg::FUNC_ADD, 24'h000100, 24'h000100, 1, 0, 0, '0});
    dir_rows.push_back('{arbt_pkg::FUNC_QUERY, 24'h000200, 24'h000000, 1, 0, 0, '0});
    dir_rows.push_back('{arbt_pkg::FUNC_QUERY, 24'h000201, 24'h000000, 1, 0, 0, '0});
    dir_rows.push_back('{FUNC_UNUSED, 24'h000100, 24'h000200, 1, 0, 0, '0});
    // Fill to capacity, then overflow
    dir_rows.push_back('{arbt_pkg::FUNC_ADD, 24'h300000, 24'h300fff, 11, 24'h011111, 0, '0});
    dir_rows.push_back('{arbt_pkg::FUNC_ADD, 24'h555555, 24'haaaaaa, 1, 0, 1, '{0, 1, 16}});
    dir_rows.push_back('{FUNC_UNUSED, 24'haaaaaa, 24'h555555, 1, 0, 1, '{0, 0, 16}});
    dir_rows.push_back('{arbt_pkg::FUNC_QUERY, 24'h300000, 24'h000000, 1, 0, 0, '0});
    dir_rows.push_back('{arbt_pkg::FUNC_CLEAR, 24'h000000, 24'hffffff, 1, 0, 1, '{0, 0, 0}});
    dir_rows.push_back('{arbt_pkg::FUNC_QUERY, 24'h000000, 24'h000000, 1, 0, 1, '{0, 0, 0}});

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed rows
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      for (int j = 0; j < row.reps; j++)
        offer_item(row.func, row.lo + addr_t'(j) * row.step, row.hi + addr_t'(j) * row.step,
                   row.typed, row.res);
    end
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait_drained();

    // Random phases, each ending with a full drain
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      n = 0;
      while (n < RANDOM_ITEMS) begin
        offer_random_item(counted);
        if (counted) n++;
      end
      req_ch.valid <= 1'b0;
      @(posedge clk);
      wait_drained();

      // Back-pressure: result side held off while items keep coming
      if (p == 0) begin
        hold_req <= ~hold_req;
        for (int j = 0; j < 12; j++) offer_random_item(counted);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/arbt_pkg.sv
design/arbt_if.sv
design/arbt_ctrl.sv
design/arbt_dpath.sv
design/address_range_breakpoint_table.sv
test/testbench.sv
